// File: hdl/aiw_pkg.sv
// Shared types and constants of the affine warp sampler.
package aiw_pkg;

  localparam int CoordW  = 8;
  localparam int ChanW   = 8;
  localparam int CoefW   = 32;
  localparam int RegIdxW = 3;
  localparam int QDepth  = 4;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam logic [RegIdxW-1:0] REG_SRC_X_PER_DST_X = 3'd0;
  localparam logic [RegIdxW-1:0] REG_SRC_X_PER_DST_Y = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SRC_X_OFFSET    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_SRC_Y_PER_DST_X = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SRC_Y_PER_DST_Y = 3'd4;
  localparam logic [RegIdxW-1:0] REG_SRC_Y_OFFSET    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_INTERP_MODE     = 3'd6;

  localparam logic signed [CoefW-1:0] CoefOneReset = 32'sd65536;

  typedef struct packed {
    logic              command;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [ChanW-1:0]  load_red;
    logic [ChanW-1:0]  load_green;
    logic [ChanW-1:0]  load_blue;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             inside_res;
  } out_item_t;

  typedef struct packed {
    logic signed [CoefW-1:0] x_per_x;
    logic signed [CoefW-1:0] x_per_y;
    logic signed [CoefW-1:0] x_off;
    logic signed [CoefW-1:0] y_per_x;
    logic signed [CoefW-1:0] y_per_y;
    logic signed [CoefW-1:0] y_off;
    logic                    mode;
  } cfg_t;

  typedef struct packed {
    logic                is_sample;
    logic [CoordW-1:0]   coord_x;
    logic [CoordW-1:0]   coord_y;
    logic [3*ChanW-1:0]  rgb;
  } job_t;

endpackage

// File: hdl/aiw_front.sv
// Front end: accepts items, drops loads outside the frame, queues the rest.
module aiw_front import aiw_pkg::*; #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  input  logic     q_full_i,
  output logic     in_stall_o,
  output logic     push_o,
  output job_t     job_o
);

  logic keep;

  // a load off the frame is accepted and discarded here
  assign keep = (in_data_i.command == CMD_SAMPLE) ||
                ((32'(in_data_i.coord_x) < FRAME_WIDTH) &&
                 (32'(in_data_i.coord_y) < FRAME_HEIGHT));

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

  assign job_o.is_sample = (in_data_i.command == CMD_SAMPLE);
  assign job_o.coord_x   = in_data_i.coord_x;
  assign job_o.coord_y   = in_data_i.coord_y;
  assign job_o.rgb       = {in_data_i.load_red, in_data_i.load_green, in_data_i.load_blue};

endmodule

// File: hdl/aiw_queue.sv
// Small FIFO between the front end and the sampling pipeline.
module aiw_queue import aiw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PtrW = $clog2(QDepth);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

// File: hdl/aiw_back.sv
// Back end: coordinate mapping, banked frame store and bilinear blend.
module aiw_back import aiw_pkg::*; #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int FRAC_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  job_t      head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int F    = FRAC_BITS;
  localparam int XW   = $clog2(FRAME_WIDTH);
  localparam int YW   = $clog2(FRAME_HEIGHT);
  localparam int PW   = CoefW + CoordW + 1;
  localparam int SW   = PW + 2;
  localparam int NW   = SW + 1 - F;
  localparam int HW   = (FRAME_WIDTH + 1) / 2;
  localparam int HH   = (FRAME_HEIGHT + 1) / 2;
  localparam int BD   = HW * HH;
  localparam int AW   = (BD > 1) ? $clog2(BD) : 1;
  localparam int WW   = 2 * F + 2;
  localparam int PrW  = WW + ChanW;
  localparam int AccW = PrW + 2;
  localparam logic [SW:0] Half = {{SW{1'b0}}, 1'b1} << (F - 1);
  localparam logic [F:0]  One  = {1'b0, {F{1'b0}}} | ({{F{1'b0}}, 1'b1} << F);

  logic en;
  assign en    = !out_valid_o || !out_stall_i;
  assign pop_o = en && !empty_i;

  // valid bits of the pipe
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;

  // ---- stage 1: products
  job_t                  j1_q;
  logic signed [PW-1:0]  pxx_q, pxy_q, pyx_q, pyy_q;
  logic signed [PW-1:0]  pxx_d, pxy_d, pyx_d, pyy_d;
  logic signed [CoordW:0] ux, uy;

  assign ux    = $signed({1'b0, head_i.coord_x});
  assign uy    = $signed({1'b0, head_i.coord_y});
  assign pxx_d = $signed(cfg_i.x_per_x) * ux;
  assign pxy_d = $signed(cfg_i.x_per_y) * uy;
  assign pyx_d = $signed(cfg_i.y_per_x) * ux;
  assign pyy_d = $signed(cfg_i.y_per_y) * uy;

  // ---- stage 2: sums
  job_t                 j2_q;
  logic signed [SW-1:0] sx_q, sy_q, sx_d, sy_d;

  assign sx_d = SW'(pxx_q) + SW'(pxy_q) + SW'($signed(cfg_i.x_off));
  assign sy_d = SW'(pyx_q) + SW'(pyy_q) + SW'($signed(cfg_i.y_off));

  // ---- stage 3: integer position, fraction, frame check
  logic [SW:0]    tx, ty;
  logic [NW-1:0]  nx, ny;
  logic           in_x, in_y;
  logic [XW-1:0]  col_d, col1_d;
  logic [YW-1:0]  row_d, row1_d;
  logic [F-1:0]   fx_d, fy_d;

  always_comb begin
    tx = (SW+1)'(sx_q) + Half;
    ty = (SW+1)'(sy_q) + Half;
    nx = tx[SW:F];
    ny = ty[SW:F];
    if (cfg_i.mode == MODE_NEAREST) begin
      // ties away from zero; anything above minus one half lands at or right of 0
      in_x  = !tx[SW] && (tx != '0) && (nx < NW'(FRAME_WIDTH));
      in_y  = !ty[SW] && (ty != '0) && (ny < NW'(FRAME_HEIGHT));
      col_d = nx[XW-1:0];
      row_d = ny[YW-1:0];
      fx_d  = '0;
      fy_d  = '0;
    end else begin
      in_x  = !sx_q[SW-1] && (sx_q[SW-1:F] < (SW-F)'(FRAME_WIDTH));
      in_y  = !sy_q[SW-1] && (sy_q[SW-1:F] < (SW-F)'(FRAME_HEIGHT));
      col_d = sx_q[F+XW-1:F];
      row_d = sy_q[F+YW-1:F];
      fx_d  = sx_q[F-1:0];
      fy_d  = sy_q[F-1:0];
    end
    col1_d = (col_d == XW'(FRAME_WIDTH - 1))  ? col_d : col_d + 1'b1;
    row1_d = (row_d == YW'(FRAME_HEIGHT - 1)) ? row_d : row_d + 1'b1;
  end

  job_t          j3_q;
  logic [XW-1:0] x0_q, x1_q;
  logic [YW-1:0] y0_q, y1_q;
  logic [F-1:0]  fx_q, fy_q;
  logic          in3_q;

  // ---- stage 4: banked frame access and weights
  logic [3*ChanW-1:0] mem_q [4][BD];
  logic [3*ChanW-1:0] rd_q [4];
  logic [AW-1:0]      raddr [4];
  logic [XW-1:0]      colb [4];
  logic [YW-1:0]      rowb [4];
  logic [XW-1:0]      lx;
  logic [YW-1:0]      ly;
  logic [AW-1:0]      waddr;
  logic [1:0]         wbank;
  logic               we;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      colb[b]  = (x0_q[0] == b[0]) ? x0_q : x1_q;
      rowb[b]  = (y0_q[0] == b[1]) ? y0_q : y1_q;
      raddr[b] = AW'((rowb[b] >> 1) * HW + (colb[b] >> 1));
    end
  end

  assign lx    = XW'(j3_q.coord_x);
  assign ly    = YW'(j3_q.coord_y);
  assign waddr = AW'((ly >> 1) * HW + (lx >> 1));
  assign wbank = {ly[0], lx[0]};
  assign we    = en && v3_q && !j3_q.is_sample;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int b = 0; b < 4; b++) begin
        if (we && (wbank == 2'(b))) begin
          mem_q[b][waddr] <= j3_q.rgb;
        end
        rd_q[b] <= mem_q[b][raddr[b]];
      end
    end
  end

  logic [F:0]    ofx, ofy, efx, efy;
  logic [WW-1:0] w_d [4];
  logic [WW-1:0] w_q [4];
  logic [1:0]    sel_d [4];
  logic [1:0]    sel_q [4];
  logic          s4_q, in4_q;

  always_comb begin
    efx      = {1'b0, fx_q};
    efy      = {1'b0, fy_q};
    ofx      = One - efx;
    ofy      = One - efy;
    w_d[0]   = ofx * ofy;
    w_d[1]   = efx * ofy;
    w_d[2]   = ofx * efy;
    w_d[3]   = efx * efy;
    sel_d[0] = {y0_q[0], x0_q[0]};
    sel_d[1] = {y0_q[0], x1_q[0]};
    sel_d[2] = {y1_q[0], x0_q[0]};
    sel_d[3] = {y1_q[0], x1_q[0]};
  end

  // ---- stage 5: channel times weight
  logic [PrW-1:0] pr_d [3][4];
  logic [PrW-1:0] pr_q [3][4];
  logic           s5_q, in5_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        pr_d[c][k] = rd_q[sel_q[k]][(3*ChanW-1-ChanW*c) -: ChanW] * w_q[k];
      end
    end
  end

  // ---- stage 6: sum and truncate into the output register
  logic [AccW-1:0] acc [3];
  out_item_t       out_d, out_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = AccW'(pr_q[c][0]) + AccW'(pr_q[c][1]) + AccW'(pr_q[c][2]) +
               AccW'(pr_q[c][3]);
    end
    out_d.out_red    = in5_q ? acc[0][2*F +: ChanW] : '0;
    out_d.out_green  = in5_q ? acc[1][2*F +: ChanW] : '0;
    out_d.out_blue   = in5_q ? acc[2][2*F +: ChanW] : '0;
    out_d.inside_res = in5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      ov_q <= v5_q && s5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j1_q  <= head_i;
      pxx_q <= pxx_d;
      pxy_q <= pxy_d;
      pyx_q <= pyx_d;
      pyy_q <= pyy_d;
      j2_q  <= j1_q;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      j3_q  <= j2_q;
      x0_q  <= col_d;
      x1_q  <= col1_d;
      y0_q  <= row_d;
      y1_q  <= row1_d;
      fx_q  <= fx_d;
      fy_q  <= fy_d;
      in3_q <= in_x && in_y;
      s4_q  <= j3_q.is_sample;
      in4_q <= in3_q;
      w_q   <= w_d;
      sel_q <= sel_d;
      s5_q  <= s4_q;
      in5_q <= in4_q;
      pr_q  <= pr_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/affine_image_warp_sampler.sv
// Top level of the affine warp sampler: configuration registers and wiring.
//
// Takes one item per clock unless the queue is full. Loads write one pixel
// into a frame store split four ways by column and row parity, so a sample
// reads all four bilinear neighbours at once. A four-entry queue sits
// between input and pipeline, so input is still taken while a result waits.
// Loads outside the frame are dropped, loads produce no result. Writes to
// the configuration port take effect at once and must happen while idle.
module affine_image_warp_sampler import aiw_pkg::*; #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  in_item_t           in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output out_item_t          out_data_o,
  input  logic               out_stall_i,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [CoefW-1:0]   cfg_data_i
);

  cfg_t cfg_q;
  job_t job, head;
  logic push, pop, q_empty, q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_per_x <= CoefOneReset;
      cfg_q.x_per_y <= '0;
      cfg_q.x_off   <= '0;
      cfg_q.y_per_x <= '0;
      cfg_q.y_per_y <= CoefOneReset;
      cfg_q.y_off   <= '0;
      cfg_q.mode    <= MODE_NEAREST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_X_PER_DST_X: cfg_q.x_per_x <= cfg_data_i;
        REG_SRC_X_PER_DST_Y: cfg_q.x_per_y <= cfg_data_i;
        REG_SRC_X_OFFSET:    cfg_q.x_off   <= cfg_data_i;
        REG_SRC_Y_PER_DST_X: cfg_q.y_per_x <= cfg_data_i;
        REG_SRC_Y_PER_DST_Y: cfg_q.y_per_y <= cfg_data_i;
        REG_SRC_Y_OFFSET:    cfg_q.y_off   <= cfg_data_i;
        REG_INTERP_MODE:     cfg_q.mode    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  aiw_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .in_stall_o(in_stall_o),
    .push_o    (push),
    .job_o     (job)
  );

  aiw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  aiw_back #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: hdl/aiw_checker.sv
// Port-level checks of the affine warp sampler, bound to the top level.
module aiw_port_props import aiw_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input out_item_t out_data_o,
  input logic      out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_outside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.inside_res |->
      out_data_o.out_red == '0 && out_data_o.out_green == '0 &&
      out_data_o.out_blue == '0)
    else $error("outside result not black");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(rst_ni, 6))
    else $error("result earlier than pipeline depth after reset");

endmodule

bind affine_image_warp_sampler aiw_port_props u_aiw_port_props (.*);

// File: sim/aiw_checker.sv
// Checker for the affine warp sampler: watches both channels, predicts results, compares.
module aiw_checker import aiw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  in_item_t           in_data_i,
  input  logic               in_stall_i,
  input  logic               out_valid_i,
  input  out_item_t          out_data_i,
  input  logic               out_stall_i,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 samples_seen_o
);

  localparam int FrameW = 256;
  localparam int FrameH = 256;
  localparam int Frac   = 16;

  logic [3*ChanW-1:0] frame_mem [FrameW*FrameH];
  cfg_t               coef;
  out_item_t          pixel_q [$];

  assign pending_o = pixel_q.size();

  function automatic logic [3*ChanW-1:0] pixel_at(int x, int y);
    return frame_mem[y*FrameW + x];
  endfunction

  function automatic longint round_half_away(longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (Frac-1))) >>> Frac;
    return v < 0 ? -m : m;
  endfunction

  function automatic out_item_t warp_pixel(logic [CoordW-1:0] dx, logic [CoordW-1:0] dy);
    out_item_t r;
    longint sx, sy, nx, ny, x0, y0, fx, fy, acc;
    longint w [4];
    logic [3*ChanW-1:0] p [4];
    int x1, y1;
    r = '0;
    sx = longint'(coef.x_per_x) * dx + longint'(coef.x_per_y) * dy + longint'(coef.x_off);
    sy = longint'(coef.y_per_x) * dx + longint'(coef.y_per_y) * dy + longint'(coef.y_off);
    if (coef.mode == MODE_NEAREST) begin
      nx = round_half_away(sx);
      ny = round_half_away(sy);
      if (nx >= 0 && ny >= 0 && nx < FrameW && ny < FrameH) begin
        {r.out_red, r.out_green, r.out_blue} = pixel_at(int'(nx), int'(ny));
        r.inside_res = 1'b1;
      end
    end else if (sx >= 0 && sy >= 0) begin
      x0 = sx >>> Frac;
      y0 = sy >>> Frac;
      if (x0 < FrameW && y0 < FrameH) begin
        fx = sx & ((64'sd1 <<< Frac) - 1);
        fy = sy & ((64'sd1 <<< Frac) - 1);
        x1 = x0 + 1 < FrameW ? int'(x0) + 1 : int'(x0);
        y1 = y0 + 1 < FrameH ? int'(y0) + 1 : int'(y0);
        p[0] = pixel_at(int'(x0), int'(y0));
        p[1] = pixel_at(x1, int'(y0));
        p[2] = pixel_at(int'(x0), y1);
        p[3] = pixel_at(x1, y1);
        w[0] = ((64'sd1 <<< Frac) - fx) * ((64'sd1 <<< Frac) - fy);
        w[1] = fx * ((64'sd1 <<< Frac) - fy);
        w[2] = ((64'sd1 <<< Frac) - fx) * fy;
        w[3] = fx * fy;
        for (int c = 0; c < 3; c++) begin
          acc = 0;
          for (int k = 0; k < 4; k++)
            acc += longint'(p[k][(2-c)*ChanW +: ChanW]) * w[k];
          acc = acc >>> (2*Frac);
          case (c)
            0: r.out_red = acc[7:0];
            1: r.out_green = acc[7:0];
            default: r.out_blue = acc[7:0];
          endcase
        end
        r.inside_res = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      coef <= '{x_per_x: CoefOneReset, y_per_y: CoefOneReset, default: '0};
      fail_count_o <= 0;
      samples_seen_o <= 0;
      pixel_q.delete();
      foreach (frame_mem[i]) frame_mem[i] = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_X_PER_DST_X: coef.x_per_x <= cfg_data_i;
          REG_SRC_X_PER_DST_Y: coef.x_per_y <= cfg_data_i;
          REG_SRC_X_OFFSET:    coef.x_off   <= cfg_data_i;
          REG_SRC_Y_PER_DST_X: coef.y_per_x <= cfg_data_i;
          REG_SRC_Y_PER_DST_Y: coef.y_per_y <= cfg_data_i;
          REG_SRC_Y_OFFSET:    coef.y_off   <= cfg_data_i;
          REG_INTERP_MODE:     coef.mode    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        samples_seen_o <= samples_seen_o + 1;
        if (pixel_q.size() == 0) begin
          $error("unexpected result %h", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = pixel_q.pop_front();
          if (e.out_red !== out_data_i.out_red)
            $error("out_red exp %h got %h", e.out_red, out_data_i.out_red);
          if (e.out_green !== out_data_i.out_green)
            $error("out_green exp %h got %h", e.out_green, out_data_i.out_green);
          if (e.out_blue !== out_data_i.out_blue)
            $error("out_blue exp %h got %h", e.out_blue, out_data_i.out_blue);
          if (e.inside_res !== out_data_i.inside_res)
            $error("inside_res exp %b got %b", e.inside_res, out_data_i.inside_res);
          if (e !== out_data_i) fail_count_o <= fail_count_o + 1;
        end
      end
      // config is only written while idle, so predicting with current coef is safe
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.command == CMD_LOAD)
          frame_mem[in_data_i.coord_y*FrameW + in_data_i.coord_x] =
            {in_data_i.load_red, in_data_i.load_green, in_data_i.load_blue};
        else
          pixel_q.push_back(warp_pixel(in_data_i.coord_x, in_data_i.coord_y));
      end
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the affine warp sampler: stimulus, configuration phases, verdict.
module tb_top;
  import aiw_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  in_item_t           in_data_i = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  out_item_t          out_data_o;
  logic               out_stall_i = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [CoefW-1:0]   cfg_data_i = '0;
  int                 fail_count, pending, samples_seen;
  longint             cycle_count = 0;
  int                 sent_items = 0;
  int                 out_hold = 0;
  logic               out_took = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  affine_image_warp_sampler DUT (.*);

  aiw_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_i(in_stall_o),
    .out_valid_i(out_valid_o), .out_data_i(out_data_o), .out_stall_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .samples_seen_o(samples_seen)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) out_took <= out_valid_o && !out_stall_i;

  // receiver: after each result transfer, draw how many cycles to stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took)
        out_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent_items++;
  endtask

  task automatic load_px(int x, int y, logic [23:0] rgb);
    send_item({CMD_LOAD, 8'(x), 8'(y), rgb});
  endtask

  task automatic sample_px(int x, int y);
    in_item_t it;
    it.command = CMD_SAMPLE;
    it.coord_x = 8'(x);
    it.coord_y = 8'(y);
    {it.load_red, it.load_green, it.load_blue} = 24'($urandom);
    send_item(it);
  endtask

  task automatic drain_and_wait();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [CoefW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_coefs(int a, int b, int c, int d, int e, int f, logic mode);
    drain_and_wait();
    write_reg(REG_SRC_X_PER_DST_X, a);
    write_reg(REG_SRC_X_PER_DST_Y, b);
    write_reg(REG_SRC_X_OFFSET, c);
    write_reg(REG_SRC_Y_PER_DST_X, d);
    write_reg(REG_SRC_Y_PER_DST_Y, e);
    write_reg(REG_SRC_Y_OFFSET, f);
    write_reg(REG_INTERP_MODE, {31'(0), mode});
  endtask

  // random samples within the given span, mixed with occasional loads anywhere
  task automatic sample_burst(int n, int span);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0)
        load_px($urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
      else
        sample_px($urandom_range(0, span), $urandom_range(0, span));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // every pixel that any sample can reach must be written first
    for (int y = 0; y < 16; y++)
      for (int x = 0; x < 16; x++)
        load_px(x, y, 24'($urandom));
    load_px(255, 255, 24'hffffff);
    load_px(0, 255, 24'h00ff00);
    load_px(255, 0, 24'h0000ff);
    load_px(255, 1, 24'h654321);
    load_px(254, 255, 24'h123456);
    load_px(255, 254, 24'hfedcba);
    load_px(254, 254, 24'h000000);
    // directed: identity nearest, at the origin and the frame extremes
    sample_px(0, 0); sample_px(15, 15); sample_px(255, 255); sample_px(0, 255);
    sample_px(255, 0);
    // half-pixel offset: ties away from zero, and negative outside
    set_coefs(65536, 0, 32768, 0, 65536, -32768, MODE_NEAREST);
    sample_px(3, 4); sample_px(0, 0); sample_px(254, 255);
    set_coefs(65536, 0, -32769, 0, 65536, 32767, MODE_NEAREST);
    sample_px(0, 0); sample_px(5, 5);
    // bilinear with fractions; clamp at last row and column
    set_coefs(65536, 0, 21845, 0, 65536, 40000, MODE_BILINEAR);
    sample_px(0, 0); sample_px(7, 9); sample_px(255, 255); sample_px(254, 254);
    sample_px(255, 0);
    set_coefs(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h7fffffff, MODE_BILINEAR);
    sample_px(0, 0); sample_px(255, 255); sample_px(0, 255);
    set_coefs(32'h80000000, 0, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff,
              MODE_NEAREST);
    sample_px(0, 0); sample_px(255, 1);
    // random phases: coefficients scaled so every sample stays inside the 16x16 window
    for (int ph = 0; ph < 8; ph++) begin
      set_coefs($urandom_range(0, 40000), $urandom_range(0, 20000),
                $urandom_range(0, 65536), $urandom_range(0, 20000),
                $urandom_range(0, 40000), $urandom_range(0, 65536),
                ph[0]);
      sample_burst(25, 15);
    end
    set_coefs(-65536, 0, 32'h7fffffff, 0, -65536, -5, MODE_BILINEAR);
    sample_burst(40, 255);
    set_coefs(65536, 0, 0, 0, 65536, 0, MODE_NEAREST);
    drain_and_wait();
    $display("tb_top: %0d items sent, %0d results checked over nearest and bilinear phases",
             sent_items, samples_seen);
    $display("tb_top: coefficient extremes, rounding ties, edge clamping and outside maps hit");
    if (fail_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: affine_image_warp_sampler.f
hdl/aiw_pkg.sv
hdl/aiw_front.sv
hdl/aiw_queue.sv
hdl/aiw_back.sv
hdl/affine_image_warp_sampler.sv
hdl/aiw_checker.sv
sim/aiw_checker.sv
sim/tb_top.sv
